// ===== hdl/thm_pkg.sv =====
package thm_pkg;

    // Fixed field widths
    localparam int SLOT_W    = 8;
    localparam int FIELD_W   = 16;
    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    // Largest offset table the slot field can address
    localparam int TABLE_MAX = 256;

    // Parameter defaults
    localparam int DEF_MAX_BLOCK_PIXELS = 256;
    localparam int DEF_SAMPLE_BITS      = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] COLUMNS_RESET = 9'd32;
    localparam logic [CFG_W-1:0] ROWS_RESET    = 9'd32;
    localparam logic [CFG_W-1:0] PIXELS_RESET  = 9'd128;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_PIXELS  = 2'd2
    } t_cfg_idx;

    // Per-transaction control from the input side to the counter unit
    typedef struct packed {
        logic accept;
        logic frame_begin;
        logic half;
        logic pixel;
    } t_step;

endpackage

// ===== hdl/thm_addr_gen.sv =====
module thm_addr_gen
    import thm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step              i_step,
    input  logic [CFG_W-1:0]   i_columns,
    input  logic [CFG_W-1:0]   i_rows,
    output logic [ADDR_W-1:0]  o_addr
);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_top_row, n_top_row;
    logic [CNT_W-1:0] r_bot_row, n_bot_row;

    logic [CNT_W-1:0] cur_col;
    logic [CNT_W-1:0] cur_top;
    logic [CNT_W-1:0] cur_bot;
    logic [CNT_W-1:0] row_sel;
    logic [CNT_W:0]   col_inc;
    logic [CNT_W+CFG_W-1:0] product;
    logic [CNT_W+CFG_W:0]   addr_full;
    logic [CNT_W-1:0] bot_start;

    assign bot_start = CNT_W'(i_rows - 9'd1);

    // Counter values seen by this transaction (frame begin restarts them first)
    assign cur_col = i_step.frame_begin ? '0 : r_col;
    assign cur_top = i_step.frame_begin ? '0 : r_top_row;
    assign cur_bot = i_step.frame_begin ? bot_start : r_bot_row;
    assign row_sel = i_step.half ? cur_bot : cur_top;

    // Frame address: column * rows + row, low bits kept
    assign product   = cur_col * i_rows;
    assign addr_full = {1'b0, product} + (CNT_W+CFG_W+1)'(row_sel);
    assign o_addr    = addr_full[ADDR_W-1:0];

    // Column wrap steps the row counter of the pixel's half
    assign col_inc = {1'b0, cur_col} + 9'd1;

    always_comb begin
        n_col     = r_col;
        n_top_row = r_top_row;
        n_bot_row = r_bot_row;
        if (i_step.accept) begin
            n_col     = cur_col;
            n_top_row = cur_top;
            n_bot_row = cur_bot;
            if (i_step.pixel) begin
                if (col_inc >= i_columns) begin
                    n_col = '0;
                    if (i_step.half) begin
                        n_bot_row = cur_bot - 8'd1;
                    end else begin
                        n_top_row = cur_top + 8'd1;
                    end
                end else begin
                    n_col = col_inc[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_top_row <= '0;
            r_bot_row <= CNT_W'(ROWS_RESET - 9'd1);
        end else begin
            r_col     <= n_col;
            r_top_row <= n_top_row;
            r_bot_row <= n_bot_row;
        end
    end

endmodule

// ===== hdl/thm_offset_mem.sv =====
module thm_offset_mem
    import thm_pkg::*;
#(
    parameter int MAX_BLOCK_PIXELS = DEF_MAX_BLOCK_PIXELS,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic                   i_rd_en,
    input  logic                   i_half,
    input  logic [SLOT_W-1:0]      i_slot,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic [CFG_W-1:0]       i_pixels,
    output logic [SAMPLE_BITS-1:0] o_offset
);

    localparam int TABLE_DEPTH = (MAX_BLOCK_PIXELS < TABLE_MAX) ? MAX_BLOCK_PIXELS : TABLE_MAX;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [SAMPLE_BITS-1:0] top_mem [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] bot_mem [TABLE_DEPTH];

    logic [SAMPLE_BITS-1:0] r_top_q;
    logic [SAMPLE_BITS-1:0] r_bot_q;
    logic                   r_half;
    logic                   r_use;

    logic             in_use;
    logic [IDX_W-1:0] idx;

    // Slot must fall inside the block in use and inside the table
    assign in_use = ({1'b0, i_slot} < i_pixels) && (32'(i_slot) < MAX_BLOCK_PIXELS);
    assign idx    = IDX_W'(i_slot);

    // Offset writes
    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_use) begin
            if (i_half) begin
                bot_mem[idx] <= i_wr_data;
            end else begin
                top_mem[idx] <= i_wr_data;
            end
        end
    end

    // Registered reads, held while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top_q <= top_mem[idx];
            r_bot_q <= bot_mem[idx];
            r_half  <= i_half;
            r_use   <= in_use;
        end
    end

    // Out-of-range slots subtract nothing
    assign o_offset = r_use ? (r_half ? r_bot_q : r_top_q) : '0;

endmodule

// ===== hdl/thm_out_stage.sv =====
module thm_out_stage
    import thm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [ADDR_W-1:0]      i_addr,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_offset,
    output logic                   o_free,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [M_TDATA_W-1:0]   o_tdata
);

    logic                   r_valid;
    logic [ADDR_W-1:0]      r_addr;
    logic [SAMPLE_BITS-1:0] r_value;
    logic [SAMPLE_BITS-1:0] diff;

    // Offset correction wraps to the sample width
    assign diff   = i_sample - i_offset;
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_addr  <= i_addr;
            r_value <= diff;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {FIELD_W'(r_value), r_addr};

endmodule

// ===== hdl/thermal_pixel_offset_reorder.sv =====
// Path: an accepted pixel transaction passes the offset table read register and then
//   the result register on its way to the master side. Offset transactions produce
//   no output. Throughput: one transaction per cycle while the master side accepts;
//   the counter update, multiply-add and subtraction each fit one stage.
// Reset (synchronous, active low): clears the pipeline, counters and configuration
//   registers to their defaults; the offset tables keep their contents.
module thermal_pixel_offset_reorder
    import thm_pkg::*;
#(
    parameter int MAX_BLOCK_PIXELS = DEF_MAX_BLOCK_PIXELS,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // slot[7:0], sample[23:8]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // frame_begin[0], half[1], kind[2]
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // pixel_address[15:0], pixel_value[31:16]
);

    logic [CFG_W-1:0] r_columns;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_pixels;

    logic                   r_s1_valid;
    logic [ADDR_W-1:0]      r_s1_addr;
    logic [SAMPLE_BITS-1:0] r_s1_sample;

    logic                   s1_free;
    logic                   s2_free;
    logic                   accept;
    logic                   is_pixel;
    logic [SLOT_W-1:0]      slot;
    logic [FIELD_W-1:0]     sample;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] offset;
    t_step                  step;

    assign slot     = s_axis_tdata[SLOT_W-1:0];
    assign sample   = s_axis_tdata[SLOT_W +: FIELD_W];
    assign is_pixel = !s_axis_tuser[2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
            r_pixels  <= PIXELS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                CFG_PIXELS:  r_pixels  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves whenever the result stage can take it
    assign s1_free       = !r_s1_valid || s2_free;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;

    assign step.accept      = accept;
    assign step.frame_begin = s_axis_tuser[0];
    assign step.half        = s_axis_tuser[1];
    assign step.pixel       = is_pixel;

    thm_addr_gen u_addr_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .o_addr    (addr)
    );

    thm_offset_mem #(
        .MAX_BLOCK_PIXELS (MAX_BLOCK_PIXELS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_offset_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !is_pixel),
        .i_rd_en   (accept && is_pixel),
        .i_half    (s_axis_tuser[1]),
        .i_slot    (slot),
        .i_wr_data (sample[SAMPLE_BITS-1:0]),
        .i_pixels  (r_pixels),
        .o_offset  (offset)
    );

    // Stage 1: address and raw sample alongside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept && is_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_pixel) begin
            r_s1_addr   <= addr;
            r_s1_sample <= sample[SAMPLE_BITS-1:0];
        end
    end

    thm_out_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_addr   (r_s1_addr),
        .i_sample (r_s1_sample),
        .i_offset (offset),
        .o_free   (s2_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/thm_checker.sv =====
module thm_checker
    import thm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input only stalls when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // An accepted pixel reaches (or queues behind) the output after the stage 1 and result registers
    a_pixel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[2]) |=> ##1 m_axis_tvalid)
        else $error("accepted pixel did not reach the output");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind thermal_pixel_offset_reorder thm_checker u_thm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import thm_pkg::*;

    // Field codes of the input transaction
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_OFFSET = 1'b1;
    localparam logic HALF_TOP    = 1'b0;
    localparam logic HALF_BOTTOM = 1'b1;

    typedef struct packed {
        logic               frame_begin;
        logic               half;
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] sample;
    } t_sensor_word;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [FIELD_W-1:0] value;
    } t_placed_pixel;

    typedef struct packed {
        t_sensor_word  word;
        logic          known;
        t_placed_pixel result;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_COLUMNS;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // slot[7:0], sample[23:8]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // frame_begin[0], half[1], kind[2]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // pixel_address[15:0], pixel_value[31:16]

    // Mirror of the block state
    logic [FIELD_W-1:0] top_table [TABLE_MAX];
    logic [FIELD_W-1:0] bottom_table [TABLE_MAX];
    bit                 top_loaded [TABLE_MAX];
    bit                 bottom_loaded [TABLE_MAX];
    logic [SLOT_W-1:0]  top_loaded_slots [$];
    logic [SLOT_W-1:0]  bottom_loaded_slots [$];
    logic [CNT_W-1:0]   column_pos = '0;
    logic [CNT_W-1:0]   top_line = '0;
    logic [CNT_W-1:0]   bottom_line = CNT_W'(ROWS_RESET - 1'b1);
    logic [CFG_W-1:0]   width_cfg = COLUMNS_RESET;
    logic [CFG_W-1:0]   height_cfg = ROWS_RESET;
    logic [CFG_W-1:0]   block_cfg = PIXELS_RESET;

    t_placed_pixel frame_writes [$];   // pixels still to come, oldest first
    int            mismatches = 0;
    int            burst_left = 0;
    bit            sender_pauses = 1'b1;
    logic [15:0]   ready_pattern = 16'hFFFF;
    logic [3:0]    ready_phase = '0;
    t_directed_row opening [16];

    thermal_pixel_offset_reorder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Receiver stalls follow a rotating 16-bit pattern
    always @(posedge i_clk) begin
        m_axis_tready <= ready_pattern[ready_phase];
        ready_phase   <= ready_phase + 1'b1;
    end

    // Offset subtraction and frame placement for one accepted word
    task automatic correct_and_place(input t_sensor_word w, output bit emits,
                                     output t_placed_pixel px);
        logic [FIELD_W-1:0] offset;
        logic [CNT_W-1:0]   line;
        bit                 in_use;
        emits  = 1'b0;
        px     = '0;
        offset = '0;
        in_use = ({1'b0, w.slot} < block_cfg);
        if (w.frame_begin) begin
            column_pos  = '0;
            top_line    = '0;
            bottom_line = CNT_W'(height_cfg - 1'b1);
        end
        if (w.kind == KIND_OFFSET) begin
            if (in_use && w.half == HALF_BOTTOM) begin
                bottom_table[w.slot] = w.sample;
                if (!bottom_loaded[w.slot]) begin
                    bottom_loaded[w.slot] = 1'b1;
                    bottom_loaded_slots.push_back(w.slot);
                end
            end else if (in_use) begin
                top_table[w.slot] = w.sample;
                if (!top_loaded[w.slot]) begin
                    top_loaded[w.slot] = 1'b1;
                    top_loaded_slots.push_back(w.slot);
                end
            end
        end else begin
            if (in_use) begin
                offset = (w.half == HALF_BOTTOM) ? bottom_table[w.slot] : top_table[w.slot];
            end
            line       = (w.half == HALF_BOTTOM) ? bottom_line : top_line;
            px.address = ADDR_W'(int'(column_pos) * int'(height_cfg) + int'(line));
            px.value   = w.sample - offset;
            emits      = 1'b1;
            // column counter is shared; the row of the pixel's half steps on wrap
            if ({1'b0, column_pos} + 9'd1 >= width_cfg) begin
                column_pos = '0;
                if (w.half == HALF_BOTTOM) begin
                    bottom_line = bottom_line - 1'b1;
                end else begin
                    top_line = top_line + 1'b1;
                end
            end else begin
                column_pos = column_pos + 1'b1;
            end
        end
    endtask

    // One input transaction, with burst/gap idling in front of it
    task automatic send_word(input t_sensor_word w, input bit known,
                             input t_placed_pixel typed);
        bit            emits;
        t_placed_pixel px;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_pauses) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.sample, w.slot};
        s_axis_tuser  <= {w.kind, w.half, w.frame_begin};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        correct_and_place(w, emits, px);
        if (emits) begin
            frame_writes.push_back(known ? typed : px);
        end
    endtask

    // Idle the input and let the pipeline empty (offset words leave no trace)
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (frame_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] lines,
                              input logic [CFG_W-1:0] block);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= lines;
        @(posedge i_clk);
        i_cfg_index <= CFG_PIXELS;
        i_cfg_data  <= block;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_cfg  = cols;
        height_cfg = lines;
        block_cfg  = block;
    endtask

    // Pixel slot: mostly a loaded entry, sometimes out of the block, sometimes anything.
    // An in-use entry never loaded must not be read, so such a word loads it instead.
    task automatic choose_pixel_slot(inout t_sensor_word w);
        bit bottom;
        int pick;
        bottom = (w.half == HALF_BOTTOM);
        pick   = $urandom_range(0, 7);
        if (pick == 0) begin
            w.slot = 8'($urandom);
        end else if (block_cfg < TABLE_MAX && pick == 1) begin
            w.slot = 8'($urandom_range(block_cfg, TABLE_MAX - 1));
        end else if (bottom && bottom_loaded_slots.size() != 0) begin
            w.slot = bottom_loaded_slots[$urandom_range(0, bottom_loaded_slots.size() - 1)];
        end else if (!bottom && top_loaded_slots.size() != 0) begin
            w.slot = top_loaded_slots[$urandom_range(0, top_loaded_slots.size() - 1)];
        end else begin
            w.slot = 8'($urandom);
        end
        if ({1'b0, w.slot} < block_cfg && !(bottom ? bottom_loaded[w.slot] : top_loaded[w.slot]))
        begin
            w.kind = KIND_OFFSET;
        end
    endtask

    // New geometry, an offset preload for both halves, then a mixed stream
    task automatic run_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] lines,
                             input logic [CFG_W-1:0] block, input int count,
                             input int frame_pm, input int top_pct, input int offset_pct,
                             input bit pauses, input logic [15:0] stalls);
        t_sensor_word w;
        int           preload;
        settle();
        set_config(cols, lines, block);
        sender_pauses = pauses;
        ready_pattern <= stalls | 16'h0001;
        preload = (block < 8) ? int'(block) : 8;
        for (int k = 0; k < 2 * preload; k++) begin
            w        = '0;
            w.kind   = KIND_OFFSET;
            w.half   = k[0];
            w.slot   = 8'(k / 2);
            w.sample = 16'($urandom);
            send_word(w, 1'b0, '0);
        end
        for (int n = 0; n < count; n++) begin
            w             = '0;
            w.sample      = 16'($urandom);
            w.half        = ($urandom_range(0, 99) < top_pct) ? HALF_TOP : HALF_BOTTOM;
            w.frame_begin = (n == 0) || ($urandom_range(0, 999) < frame_pm);
            if ($urandom_range(0, 99) < offset_pct) begin
                w.kind = KIND_OFFSET;
                w.slot = 8'($urandom);
            end else begin
                w.kind = KIND_PIXEL;
                choose_pixel_slot(w);
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // Check each output transaction against the oldest pending pixel
    always @(posedge i_clk) begin : check_pixels
        t_placed_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_writes.size() == 0) begin
                $display("%0t: unexpected pixel, address %h value %h", $time,
                         m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W +: FIELD_W]);
                mismatches++;
            end else begin
                want = frame_writes.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== want.address) begin
                    $display("%0t: pixel_address expected %h actual %h", $time,
                             want.address, m_axis_tdata[ADDR_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[ADDR_W +: FIELD_W] !== want.value) begin
                    $display("%0t: pixel_value expected %h actual %h", $time,
                             want.value, m_axis_tdata[ADDR_W +: FIELD_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        // frame_begin, half, kind, slot, sample | typed? | address, value (defaults 32x32, 128)
        opening = '{
            '{'{1'b1, HALF_TOP,    KIND_OFFSET, 8'd0,   16'h0000}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd0,   16'h7FFF}, 1'b1, '{16'd0,   16'h7FFF}},
            '{'{1'b0, HALF_BOTTOM, KIND_OFFSET, 8'd0,   16'h8000}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_BOTTOM, KIND_PIXEL,  8'd0,   16'h7FFF}, 1'b1, '{16'd63,  16'hFFFF}},
            '{'{1'b0, HALF_TOP,    KIND_OFFSET, 8'd127, 16'hFFFF}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd127, 16'h0000}, 1'b1, '{16'd64,  16'h0001}},
            // slots past the block: offset ignored, pixel sees zero
            '{'{1'b0, HALF_TOP,    KIND_OFFSET, 8'd128, 16'h1234}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd128, 16'h8000}, 1'b1, '{16'd96,  16'h8000}},
            '{'{1'b0, HALF_BOTTOM, KIND_OFFSET, 8'd255, 16'h5555}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_BOTTOM, KIND_PIXEL,  8'd255, 16'hAAAA}, 1'b1, '{16'd159, 16'hAAAA}},
            // frame begin on an offset word still restarts the counters
            '{'{1'b1, HALF_TOP,    KIND_OFFSET, 8'd1,   16'h00FF}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd1,   16'h0100}, 1'b1, '{16'd0,   16'h0001}},
            '{'{1'b0, HALF_TOP,    KIND_OFFSET, 8'd2,   16'h7FFF}, 1'b0, '{16'd0,   16'h0000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd2,   16'h8000}, 1'b1, '{16'd32,  16'h0001}},
            '{'{1'b1, HALF_BOTTOM, KIND_PIXEL,  8'd0,   16'h0000}, 1'b1, '{16'd31,  16'h8000}},
            '{'{1'b0, HALF_TOP,    KIND_PIXEL,  8'd0,   16'hFFFF}, 1'b0, '{16'd0,   16'h0000}}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        ready_pattern <= 16'($urandom) | 16'h0001;

        foreach (opening[i]) begin
            send_word(opening[i].word, opening[i].known, opening[i].result);
        end

        // one column: row steps per pixel, top row wraps past 255, bottom below 0
        run_phase(9'd1, 9'd2, 9'd1, 270, 0, 98, 1, 1'b1, 16'($urandom));
        // widest geometry: 256-row stride and full 9-bit register values
        run_phase(9'd256, 9'd256, 9'd256, 30, 0, 50, 5, 1'b1, 16'($urandom));
        // small odd geometry, frequent frame restarts, no idling on either side
        run_phase(9'd5, 9'd3, 9'd8, 40, 50, 50, 20, 1'b0, 16'hFFFF);
        // back to the reset geometry
        run_phase(COLUMNS_RESET, ROWS_RESET, PIXELS_RESET, 20, 20, 50, 15, 1'b1,
                  16'($urandom));

        settle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
